[design/slir_pkg.sv]
// shared constants and types for the sorted insertion list
package slir_pkg;

   // list geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // beat field widths
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture the request beat
      logic compare;   // register per-cell compare flags
      logic commit;    // update the list and the result register
   } dp_cmd_type;

endpackage

[design/slir_ctrl.sv]
// controller state machine for the sorted insertion list
module slir_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output slir_pkg::dp_cmd_type     dp_cmd
);
   import slir_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_UPD  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result slot can take a new beat this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      dp_cmd.load    = 1'b0;
      dp_cmd.compare = 1'b0;
      dp_cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_CMP;
            end
         end
         ST_CMP: begin
            dp_cmd.compare = 1'b1;
            state_in       = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid holds until the beat is taken
   always_comb begin
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/slir_dp.sv]
// cell array, compare flags and result register of the sorted insertion list
module slir_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  slir_pkg::dp_cmd_type              dp_cmd,
   input  logic                              req_command,
   input  logic signed [slir_pkg::VALUE_W-1:0] req_value,
   output logic [slir_pkg::STATUS_W-1:0]     rsp_status,
   output logic [slir_pkg::POS_W-1:0]        rsp_position,
   output logic [slir_pkg::COUNT_W-1:0]      rsp_count
);
   import slir_pkg::*;

   logic                       cmd_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic signed [VALUE_W-1:0]  cells_ff [DEPTH];
   logic signed [VALUE_W-1:0]  cells_in [DEPTH];
   logic signed [VALUE_W-1:0]  up_val   [DEPTH];
   logic signed [VALUE_W-1:0]  down_val [DEPTH];
   logic [DEPTH-1:0]           lt_ff, lt_in;
   logic [DEPTH-1:0]           eq_ff, eq_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           ins_pos, rem_pos, pos_sel;
   logic                       full, empty, hit, done;
   logic [STATUS_W-1:0]        status_sel;
   logic [STATUS_W-1:0]        status_ff;
   logic [POS_W-1:0]           position_ff;
   logic [COUNT_W-1:0]         rsp_count_ff;

   // operand capture
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
      end
   end

   // per-cell compare against the operand, valid cells only
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         lt_in[k] = (CNT_W'(k) < count_ff) && (cells_ff[k] < value_ff);
         eq_in[k] = (CNT_W'(k) < count_ff) && (cells_ff[k] == value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   // insert point: first cell not below the operand
   always_comb begin
      ins_pos = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (!lt_ff[k]) begin
            ins_pos = IDX_W'(k);
         end
      end
   end

   // remove point: first equal cell
   always_comb begin
      rem_pos = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (eq_ff[k]) begin
            rem_pos = IDX_W'(k);
         end
      end
   end

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign hit   = |eq_ff;

   // status and position
   always_comb begin
      unique case (cmd_ff)
         CMD_INSERT: begin
            status_sel = full ? STATUS_FULL : STATUS_DONE;
            pos_sel    = ins_pos;
         end
         CMD_REMOVE: begin
            priority if (empty) begin
               status_sel = STATUS_EMPTY;
            end else if (!hit) begin
               status_sel = STATUS_NOT_FOUND;
            end else begin
               status_sel = STATUS_DONE;
            end
            pos_sel = rem_pos;
         end
         default: begin
            status_sel = STATUS_DONE;
            pos_sel    = '0;
         end
      endcase
   end

   assign done = (status_sel == STATUS_DONE);

   // neighbor values for the shift
   always_comb begin
      up_val[0] = value_ff;
      for (int k = 1; k < DEPTH; k++) begin
         up_val[k] = cells_ff[k-1];
      end
      for (int k = 0; k < DEPTH - 1; k++) begin
         down_val[k] = cells_ff[k+1];
      end
      down_val[DEPTH-1] = cells_ff[DEPTH-1];
   end

   // next cell contents
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         cells_in[k] = cells_ff[k];
         if (done && cmd_ff == CMD_INSERT) begin
            if (IDX_W'(k) == ins_pos) begin
               cells_in[k] = value_ff;
            end else if (IDX_W'(k) > ins_pos) begin
               cells_in[k] = up_val[k];
            end
         end else if (done && cmd_ff == CMD_REMOVE) begin
            if (IDX_W'(k) >= rem_pos) begin
               cells_in[k] = down_val[k];
            end
         end
      end
   end

   // next count
   always_comb begin
      count_in = count_ff;
      if (done) begin
         if (cmd_ff == CMD_INSERT) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   // list cells
   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         for (int k = 0; k < DEPTH; k++) begin
            cells_ff[k] <= cells_in[k];
         end
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (dp_cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         status_ff    <= status_sel;
         position_ff  <= done ? POS_W'(pos_sel) : '0;
         rsp_count_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_status   = status_ff;
   assign rsp_position = position_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

[design/sorted_list_insert_remove.sv]
// top level of the sorted insertion list
//
//   channel | direction | handshake            | fields
//   req     | in        | req_valid/req_stall  | command, value
//   rsp     | out       | rsp_valid/rsp_stall  | status, position, count
//
// each command runs through capture, compare in every cell, then update
// a result waits in an output register; the next command is captured meanwhile
// and its update waits only while that result is still stalled
// synchronous reset empties the list; cell contents are not cleared
module sorted_list_insert_remove (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [slir_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [slir_pkg::STATUS_W-1:0]       rsp_status,
   output logic [slir_pkg::POS_W-1:0]          rsp_position,
   output logic [slir_pkg::COUNT_W-1:0]        rsp_count
);
   import slir_pkg::*;

   dp_cmd_type dp_cmd;

   // sequencing
   slir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   // list storage and result
   slir_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

endmodule

[tb/tb.sv]
// testbench for the sorted insertion list: queued stimulus, in-order result checking
`timescale 1ns / 1ps

module tb;
   import slir_pkg::*;

   // expected result of one command
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
   } list_result_type;

   // one command waiting to be offered
   typedef struct packed {
      logic                      command;
      logic signed [VALUE_W-1:0] value;
   } list_cmd_type;

   localparam int RANDOM_CMDS = 600;
   localparam int QUIET_TAIL  = 100;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_command = CMD_INSERT;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [POS_W-1:0]          rsp_position;
   logic [COUNT_W-1:0]        rsp_count;

   list_cmd_type    cmd_queue[$];
   list_result_type expected_results[$];
   int              total_cmds = 0;
   int              cmds_accepted = 0;
   int              errors = 0;
   int              req_gap = 0;
   int              rsp_gap = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;
   bit              quiet;

   // shadow copy of the list
   logic signed [VALUE_W-1:0] list_vals [0:DEPTH-1];
   int                        list_len = 0;

   sorted_list_insert_remove uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign quiet = (cmds_accepted >= total_cmds - QUIET_TAIL);

   // apply one command to the shadow list and queue its result
   task automatic list_apply(input logic cmd, input logic signed [VALUE_W-1:0] v);
      list_result_type r;
      int i;
      int j;
      r.status   = STATUS_DONE;
      r.position = '0;
      if (cmd == CMD_INSERT) begin
         if (list_len >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            i = 0;
            while (i < list_len && list_vals[i] < v) i++;
            for (j = list_len; j > i; j--) list_vals[j] = list_vals[j-1];
            list_vals[i] = v;
            list_len++;
            r.position = i[POS_W-1:0];
         end
      end else if (list_len == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         i = 0;
         while (i < list_len && list_vals[i] != v) i++;
         if (i == list_len) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            for (j = i; j + 1 < list_len; j++) list_vals[j] = list_vals[j+1];
            list_len--;
            r.position = i[POS_W-1:0];
         end
      end
      r.count = list_len[COUNT_W-1:0];
      expected_results.push_back(r);
   endtask

   task automatic add_cmd(input logic cmd, input logic signed [VALUE_W-1:0] v);
      list_cmd_type c;
      c.command = cmd;
      c.value   = v;
      cmd_queue.push_back(c);
      total_cmds++;
   endtask

   // value source leaning toward extremes and small repeated values
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'sh7FFF_FFFF;
         1: v = 32'sh8000_0000;
         2: v = '0;
         3: v = -32'sd1;
         4, 5: v = ($urandom_range(0, 7) << 16) - 32'sh0003_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // driver: offer queued beats, predict on acceptance
   always @(posedge clock) begin
      list_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            list_apply(req_command, req_value);
            cmds_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               c = cmd_queue.pop_front();
               req_valid   <= 1'b1;
               req_command <= c.command;
               req_value   <= c.value;
               if (!quiet && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check accepted results, drive stall bursts and one long hold-off
   always @(posedge clock) begin
      list_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat status %0d position %0d count %0d",
                        $time, rsp_status, rsp_position, rsp_count);
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_status !== e.status) begin
                  $display("%0t: status mismatch expected %0d actual %0d",
                           $time, e.status, rsp_status);
                  errors++;
               end
               if (rsp_position !== e.position) begin
                  $display("%0t: position mismatch expected %0d actual %0d",
                           $time, e.position, rsp_position);
                  errors++;
               end
               if (rsp_count !== e.count) begin
                  $display("%0t: count mismatch expected %0d actual %0d",
                           $time, e.count, rsp_count);
                  errors++;
               end
            end
         end
         if (!hold_done && cmds_accepted >= 200) begin
            hold_done = 1'b1;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int n;
      int k;
      int insert_pct;
      logic signed [VALUE_W-1:0] pool [0:9];

      // directed: empty remove, extremes, equal values, misses, fill to full
      add_cmd(CMD_REMOVE, 32'sd0);
      add_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
      add_cmd(CMD_INSERT, 32'sh8000_0000);
      add_cmd(CMD_INSERT, 32'sd0);
      add_cmd(CMD_INSERT, -32'sd1);
      add_cmd(CMD_INSERT, 32'sd1);
      add_cmd(CMD_INSERT, 32'sd0);
      add_cmd(CMD_REMOVE, 32'sh0001_2345);
      add_cmd(CMD_REMOVE, 32'sd0);
      add_cmd(CMD_REMOVE, 32'sh8000_0000);
      add_cmd(CMD_REMOVE, 32'sh7FFF_FFFF);
      for (k = 0; k < 13; k++) add_cmd(CMD_INSERT, (k - 6) * 32'sh0001_0000);
      add_cmd(CMD_INSERT, 32'sh5555_AAAA);
      add_cmd(CMD_REMOVE, 32'sh0001_0000);
      add_cmd(CMD_REMOVE, 32'sh0001_0000);

      // random: phases alternate between filling and draining
      insert_pct = 80;
      for (n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 60 == 0) begin
            insert_pct = ((n / 60) % 2 == 0) ? 80 : 25;
            for (k = 0; k < 10; k++) pool[k] = pick_value();
         end
         if ($urandom_range(0, 99) < insert_pct) begin
            if ($urandom_range(0, 9) < 7) add_cmd(CMD_INSERT, pool[$urandom_range(0, 9)]);
            else add_cmd(CMD_INSERT, pick_value());
         end else begin
            if ($urandom_range(0, 9) < 8) add_cmd(CMD_REMOVE, pool[$urandom_range(0, 9)]);
            else add_cmd(CMD_REMOVE, $urandom);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain
      while (cmd_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
